// ===== src/bmorph_pkg.sv =====
package bmorph_pkg;

    // sizes
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int COORD_W       = 10;
    localparam int DIM_W         = 11;
    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int LINE_W        = 2 * PIX_W;
    localparam int MASK_W        = 9;
    localparam int LIM_W         = 10;
    localparam int NUM_RES       = 4;
    localparam int SEL_W         = $clog2(NUM_RES);

    // stream and config port widths
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    // reset values
    localparam int THRESH_RST_I = 200;
    localparam logic [MASK_W-1:0] MASK_RST   = 9'd186;
    localparam logic [LIM_W-1:0]  FG_LIM_RST = LIM_W'(3 * THRESH_RST_I + 3);
    localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd480;

    // frame size limits
    localparam logic [DIM_W-1:0] DIM_MIN    = 11'd3;
    localparam logic [DIM_W-1:0] HEIGHT_MAX = 11'd1024;

    localparam logic [PIX_W-1:0] PIX_WHITE = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_BLACK = {PIX_W{1'b0}};

    // pixel word: blue in the top byte, red in the bottom byte
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
    } res_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] w_last;
        logic [COORD_W-1:0] h_last;
    } item_t;

    typedef struct packed {
        logic              dilate;
        logic [MASK_W-1:0] mask;
        logic [LIM_W-1:0]  fg_lim;
    } kcfg_t;

endpackage

// ===== src/bmorph_line_ram.sv =====
module bmorph_line_ram #(
    parameter int DEPTH = bmorph_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(bmorph_pkg::MAX_WIDTH_DEF)
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [bmorph_pkg::LINE_W-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [bmorph_pkg::LINE_W-1:0] wr_data
);
    import bmorph_pkg::*;

    // word = {older line, newer line}
    logic [LINE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/bmorph_kernel.sv =====
module bmorph_kernel (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       adv,
    input  bmorph_pkg::item_t                          item,
    input  bmorph_pkg::kcfg_t                          cfg,
    input  logic [bmorph_pkg::LINE_W-1:0]              line_rd,
    output bmorph_pkg::res_t [bmorph_pkg::NUM_RES-1:0] res,
    output logic [bmorph_pkg::NUM_RES-1:0]             res_vld
);
    import bmorph_pkg::*;

    logic [PIX_W-1:0] win_reg [2][3];
    logic [PIX_W-1:0] cur [3];
    logic [MASK_W-1:0] fg;
    logic [PIX_W-1:0] p;
    logic [LIM_W-1:0] sum;
    logic all_fg, any_fg, r_ge1, c_ge1, core;
    logic [COORD_W-1:0] rm1, cm1;
    logic [PIX_W-1:0] val;

    assign cur[0] = line_rd[LINE_W-1:PIX_W];
    assign cur[1] = line_rd[PIX_W-1:0];
    assign cur[2] = item.pix;

    // foreground: floor(sum/3) > thr  <=>  sum >= 3*thr+3
    always_comb
    begin
        fg = '0;
        p  = '0;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p = (j == 2) ? cur[i] : win_reg[j][i];
                sum = LIM_W'(p[23:16]) + LIM_W'(p[15:8]) + LIM_W'(p[7:0]);
                fg[i*3+j] = (sum >= cfg.fg_lim);
            end
        end
    end

    assign all_fg = &(fg | ~cfg.mask);
    assign any_fg = |(fg & cfg.mask);

    assign r_ge1 = (item.row != '0);
    assign c_ge1 = (item.col != '0);
    assign rm1   = item.row - 1'b1;
    assign cm1   = item.col - 1'b1;
    assign core  = (item.row >= COORD_W'(2)) && (item.col >= COORD_W'(2));

    always_comb
    begin
        val = win_reg[1][1];
        if (core)
        begin
            if (cfg.dilate)
            begin
                val = any_fg ? PIX_WHITE : PIX_BLACK;
            end
            else
            begin
                val = all_fg ? win_reg[1][1] : PIX_BLACK;
            end
        end
    end

    always_comb
    begin
        res_vld[0] = r_ge1 && c_ge1;
        res[0]     = '{row: rm1, col: cm1, pix: val};
        res_vld[1] = r_ge1 && (item.col == item.w_last);
        res[1]     = '{row: rm1, col: item.w_last, pix: cur[1]};
        res_vld[2] = (item.row == item.h_last) && c_ge1;
        res[2]     = '{row: item.h_last, col: cm1, pix: win_reg[1][2]};
        res_vld[3] = (item.row == item.h_last) && (item.col == item.w_last);
        res[3]     = '{row: item.h_last, col: item.w_last, pix: item.pix};
    end

    // two window columns behind the incoming one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 2; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[j][i] <= '0;
                end
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[0][i] <= win_reg[1][i];
                win_reg[1][i] <= cur[i];
            end
        end
    end

endmodule

// ===== src/bmorph_emit.sv =====
module bmorph_emit (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  bmorph_pkg::res_t [bmorph_pkg::NUM_RES-1:0] res_in,
    input  logic [bmorph_pkg::NUM_RES-1:0]             vld_in,
    output logic                                       free,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic                                       out_last,
    output bmorph_pkg::res_t                           out_res
);
    import bmorph_pkg::*;

    logic [NUM_RES-1:0] vld_reg;
    res_t [NUM_RES-1:0] res_reg;
    logic [SEL_W-1:0]   sel;
    logic               single, hs;

    // lowest pending slot goes first
    always_comb
    begin
        sel = '0;
        for (int k = NUM_RES - 1; k >= 0; k--)
        begin
            if (vld_reg[k])
            begin
                sel = SEL_W'(k);
            end
        end
    end

    assign single    = (vld_reg != '0) && ((vld_reg & (vld_reg - 1'b1)) == '0);
    assign out_valid = (vld_reg != '0);
    assign out_last  = single;
    assign out_res   = res_reg[sel];
    assign hs        = out_valid && out_ready;
    assign free      = (vld_reg == '0) || (single && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (load)
        begin
            vld_reg <= vld_in;
        end
        else if (hs)
        begin
            vld_reg[sel] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

// ===== src/binary_erode_dilate_3x3_top.sv =====
// Path: an accepted item is held in stage 1, then its results are loaded into the result
//   queue, which drives m_tdata. Throughput: one item per cycle while each item yields at
//   most one result and m_tready stays high; an item with more results (row end, last
//   row) holds the input while its results leave the queue, one per cycle while m_tready is high.
// Reset: counters, window, queue and stage valid clear, config registers take their
//   reset values at once (async, rst_n low); the line RAM is not cleared.
module binary_erode_dilate_3x3_top #(
    parameter int MAX_WIDTH = bmorph_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmorph_pkg::S_DATA_W-1:0]   s_tdata,   // red_in, green_in, blue_in
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bmorph_pkg::M_DATA_W-1:0]   m_tdata,   // 4'b0, red_out, green_out,
                                                         // blue_out, out_col, out_row
    output logic                              m_tlast,   // last_result
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [bmorph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmorph_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bmorph_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);

    // ---------------------------------------------------------------
    // Config registers. Threshold is kept as 3*thr+3 so the per-pixel
    // foreground test is a channel sum and one compare.
    // ---------------------------------------------------------------
    logic              mode_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [LIM_W-1:0]  fg_lim_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            mask_reg   <= MASK_RST;
            fg_lim_reg <= FG_LIM_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_wdata[0];
                REG_MASK:   mask_reg   <= cfg_wdata[MASK_W-1:0];
                REG_THRESH: fg_lim_reg <= LIM_W'({cfg_wdata[7:0], 1'b0})
                                        + LIM_W'(cfg_wdata[7:0]) + LIM_W'(3);
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // clamped frame size
    logic [DIM_W-1:0] w_cl, h_cl;
    assign w_cl = (width_reg < DIM_MIN) ? DIM_MIN
                : ((width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg);
    assign h_cl = (height_reg < DIM_MIN) ? DIM_MIN
                : ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);

    // ---------------------------------------------------------------
    // Raster position. A stale position (frame size changed mid-frame)
    // is folded back before use.
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [COORD_W-1:0] cur_c, cur_r;
    logic [DIM_W-1:0]   row_a, col_inc, row_inc;
    logic               col_wrap;
    logic               s_acc, s1_adv, emit_free;

    assign col_wrap = ({1'b0, col_reg} >= w_cl);
    assign cur_c    = col_wrap ? '0 : col_reg;
    assign row_a    = col_wrap ? ({1'b0, row_reg} + 1'b1) : {1'b0, row_reg};
    assign cur_r    = (row_a >= h_cl) ? '0 : row_a[COORD_W-1:0];
    assign col_inc  = {1'b0, cur_c} + 1'b1;
    assign row_inc  = {1'b0, cur_r} + 1'b1;

    always_comb
    begin
        if (col_inc >= w_cl)
        begin
            col_next = '0;
            row_next = (row_inc >= h_cl) ? '0 : row_inc[COORD_W-1:0];
        end
        else
        begin
            col_next = col_inc[COORD_W-1:0];
            row_next = cur_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: holds the item while the line RAM read completes.
    // Same RAM word is touched again only W >= 3 items later, so the
    // write-back here never collides with a pending read.
    // ---------------------------------------------------------------
    logic  s1_valid_reg;
    item_t s1_item_reg;
    logic [LINE_W-1:0] line_rd;

    assign s_acc    = s_tvalid && s_tready;
    assign s1_adv   = s1_valid_reg && emit_free;
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_item_reg.row    <= cur_r;
            s1_item_reg.col    <= cur_c;
            s1_item_reg.pix    <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
            s1_item_reg.w_last <= COORD_W'(w_cl - 1'b1);
            s1_item_reg.h_last <= COORD_W'(h_cl - 1'b1);
        end
    end

    // read {line r-2, line r-1} at accept; write back {line r-1, this pixel}
    bmorph_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (s_acc),
        .rd_addr (AW'(cur_c)),
        .rd_data (line_rd),
        .wr_en   (s1_adv),
        .wr_addr (AW'(s1_item_reg.col)),
        .wr_data ({line_rd[PIX_W-1:0], s1_item_reg.pix})
    );

    // ---------------------------------------------------------------
    // Window and result formation
    // ---------------------------------------------------------------
    kcfg_t                kcfg;
    res_t [NUM_RES-1:0]   res;
    logic [NUM_RES-1:0]   res_vld;
    res_t                 out_res;

    assign kcfg = '{dilate: mode_reg, mask: mask_reg, fg_lim: fg_lim_reg};

    bmorph_kernel u_kernel (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (s1_adv),
        .item    (s1_item_reg),
        .cfg     (kcfg),
        .line_rd (line_rd),
        .res     (res),
        .res_vld (res_vld)
    );

    // result queue: up to four results per item, one per cycle while m_tready is high
    bmorph_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .res_in    (res),
        .vld_in    (res_vld),
        .free      (emit_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .out_res   (out_res)
    );

    assign m_tdata = {4'b0000,
                      out_res.pix[7:0], out_res.pix[15:8], out_res.pix[23:16],
                      out_res.col, out_res.row};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_rw_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s1_valid_reg) |-> (cur_c != s1_item_reg.col))
        else $error("line RAM read hits entry still pending write-back");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s1_adv)
        else $error("result queue reloaded with results still pending");

    a_results_show: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (res_vld != '0)) |=> m_tvalid)
        else $error("loaded results not presented");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> s1_valid_reg)
        else $error("accepted item lost before stage 1");

endmodule
